// ----- sv/bfwm_pkg.sv -----
// Shared types, constants and codes of the box mean filter.
package bfwm_pkg;

  localparam int DEF_MAX_WINDOW = 15;
  localparam int DEF_MAX_WIDTH  = 1024;
  localparam int DEF_MAX_HEIGHT = 1024;

  localparam int PIX_W   = 8;
  localparam int KW      = 4;
  localparam int CFG_W   = 11;
  localparam int CIDX_W  = 2;
  localparam int KK_W    = 2 * KW;
  localparam int SUM_W   = 16;

  // Reciprocal of K*K scaled by 2**RECIP_SH, rounded up.
  localparam int RECIP_SH = 24;
  localparam int RECIP_W  = RECIP_SH + 1;
  localparam int PROD_W   = SUM_W + RECIP_W;

  localparam logic [KW-1:0]    RST_WINDOW = KW'(3);
  localparam logic [CFG_W-1:0] RST_WIDTH  = CFG_W'(640);
  localparam logic [CFG_W-1:0] RST_HEIGHT = CFG_W'(480);

  localparam logic [CIDX_W-1:0] REG_WINDOW = 2'd0;
  localparam logic [CIDX_W-1:0] REG_WIDTH  = 2'd1;
  localparam logic [CIDX_W-1:0] REG_HEIGHT = 2'd2;

  localparam logic KIND_PIXEL = 1'b0;
  localparam logic KIND_DRAIN = 1'b1;

  typedef struct packed {
    logic             kind;
    logic [PIX_W-1:0] pixel_in;
  } in_item_t;

  typedef struct packed {
    logic [PIX_W-1:0] pixel_out;
    logic             frame_end;
  } out_item_t;

  typedef struct packed {
    logic             done;
    logic [PIX_W-1:0] quotient;
  } div_res_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SWEEP,
    ST_FLUSH,
    ST_DIV,
    ST_OUT
  } state_t;

endpackage

// ----- sv/bfwm_line_store.sv -----
// Line store memory: one write port, one registered read port.
module bfwm_line_store import bfwm_pkg::*; #(
  parameter int AW = 14
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [PIX_W-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [PIX_W-1:0] rdata
);

  logic [PIX_W-1:0] mem [2**AW];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- sv/bfwm_mean_div.sv -----
// Rounded window mean: latch the sum, then multiply by a tabulated reciprocal of K*K.
module bfwm_mean_div import bfwm_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [SUM_W-1:0] dividend,
  input  logic [KK_W-1:0]  divisor,
  output div_res_t         res
);

  logic [SUM_W-1:0]   num;
  logic [RECIP_W-1:0] recip;
  logic [PIX_W-1:0]   quo;
  logic               busy;
  logic               done;
  logic [PROD_W-1:0]  prod;

  // Only odd K*K up to 225 and the pass-through divisor of one occur.
  function automatic logic [RECIP_W-1:0] recip_of(input logic [KK_W-1:0] d);
    logic [RECIP_W-1:0] m;
    case (d)
      KK_W'(9):   m = RECIP_W'(1864136);
      KK_W'(25):  m = RECIP_W'(671089);
      KK_W'(49):  m = RECIP_W'(342393);
      KK_W'(81):  m = RECIP_W'(207127);
      KK_W'(121): m = RECIP_W'(138655);
      KK_W'(169): m = RECIP_W'(99274);
      KK_W'(225): m = RECIP_W'(74566);
      default:    m = RECIP_W'(1) << RECIP_SH;
    endcase
    return m;
  endfunction

  assign prod = PROD_W'(num) * PROD_W'(recip);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      busy <= start;
      done <= busy;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      num   <= dividend;
      recip <= recip_of(divisor);
    end
    if (busy) begin
      quo <= prod[RECIP_SH +: PIX_W];
    end
  end

  assign res.done     = done;
  assign res.quotient = quo;

endmodule

// ----- sv/box_filter_window_mean_top.sv -----
// Top level of the K by K box mean filter over a grey pixel stream.
//
// Input channel (in_valid / in_ready / in_data): one beat per pixel in raster
// order (kind = pixel), or a drain tick (kind = drain) once the last pixel of
// the frame is in. Each beat yields zero or one output beat.
// Output channel (out_valid / out_ready / out_data): filtered or passed-through
// pixels in raster order; frame_end marks the last pixel of the frame.
// Output n leaves with input n + c*W + c, c = K/2; drain ticks release the
// rest. Config port (cfg_we / cfg_index / cfg_data): window size, width,
// height; any write restarts the frame. Write only while idle.
// Flow: one item at a time. A beat with no result leaves the block idle. A
// beat with a result walks its window through the line store, one read per
// cycle (K*K reads when filtering, one read at the frame border or in
// pass-through), then goes through the flush state and the mean unit (latch
// the sum, then multiply by the reciprocal of K*K) before the output beat is
// offered; the next input beat is taken only after the output beat leaves.
// The single read port of the line store sets the pace of the walk.
// Reset: counters and config return to their defaults (K = 3, 640 x 480);
// the line store is not cleared, every read hits a pixel of this frame.
// A stalled receiver holds the result in the output register and keeps
// in_ready low until the beat is taken.
module box_filter_window_mean_top import bfwm_pkg::*; #(
  parameter int MAX_WINDOW = DEF_MAX_WINDOW,
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  in_item_t          in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output out_item_t         out_data,
  input  logic              cfg_we,
  input  logic [CIDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]  cfg_data
);

  localparam int SRW = $clog2(MAX_WINDOW + 1);
  localparam int XW  = $clog2(MAX_WIDTH);
  localparam int DW  = $clog2(MAX_WIDTH + 1);
  localparam int HW  = $clog2(MAX_HEIGHT + 1);
  localparam int NW  = DW + HW;
  localparam int AW  = SRW + XW;

  // Configuration registers.
  logic [KW-1:0]    window_size;
  logic [CFG_W-1:0] frame_width;
  logic [CFG_W-1:0] frame_height;

  // Frame counters.
  logic [HW-1:0] in_row;
  logic [XW-1:0] in_col;
  logic [NW-1:0] in_index;
  logic [HW-1:0] out_row;
  logic [XW-1:0] out_col;
  logic [NW-1:0] out_index;

  // Window sweep registers.
  logic [HW-1:0]    sw_row;
  logic [HW-1:0]    sw_row_end;
  logic [XW-1:0]    sw_col;
  logic [XW-1:0]    sw_col_start;
  logic [XW-1:0]    sw_col_end;
  logic [KK_W-1:0]  divisor;
  logic [SUM_W-1:0] acc;
  logic             rd_vld;
  logic             frame_end;

  state_t state, state_next;

  logic [DW-1:0]    w_eff;
  logic [HW-1:0]    h_eff;
  logic [KW-2:0]    c;
  logic [KK_W-1:0]  kk;
  logic [NW-1:0]    delay;
  logic [NW-1:0]    total;
  logic             filt;
  logic             in_fire;
  logic             pix_take;
  logic             emit;
  logic             last_out;
  logic             col_wrap;
  logic             sweep_last;
  logic             rd_en;
  logic             div_start;
  logic [PIX_W-1:0] rdata;
  div_res_t         div_res;

  // Clamp the geometry to what the line store holds.
  always_comb begin
    if (frame_width == '0) begin
      w_eff = DW'(1);
    end else if (32'(frame_width) > MAX_WIDTH) begin
      w_eff = DW'(MAX_WIDTH);
    end else begin
      w_eff = DW'(frame_width);
    end
    if (frame_height == '0) begin
      h_eff = HW'(1);
    end else if (32'(frame_height) > MAX_HEIGHT) begin
      h_eff = HW'(MAX_HEIGHT);
    end else begin
      h_eff = HW'(frame_height);
    end
  end

  assign c     = window_size[KW-1:1];
  assign kk    = {{KW{1'b0}}, window_size} * {{KW{1'b0}}, window_size};
  assign delay = NW'(c) * NW'(w_eff) + NW'(c);
  assign total = NW'(w_eff) * NW'(h_eff);

  // Filter only where the whole window sits inside the frame.
  assign filt = window_size[0] && 32'(window_size) <= MAX_WINDOW
             && 32'(window_size) <= 32'(w_eff) && 32'(window_size) <= 32'(h_eff)
             && 32'(out_row) >= 32'(c) && 32'(out_row) + 32'(c) < 32'(h_eff)
             && 32'(out_col) >= 32'(c) && 32'(out_col) + 32'(c) < 32'(w_eff);

  assign in_fire  = in_valid && in_ready;
  assign pix_take = in_fire && in_data.kind == KIND_PIXEL && 32'(in_row) < 32'(h_eff);
  assign emit     = (pix_take && in_index >= delay)
                 || (in_fire && in_data.kind == KIND_DRAIN
                     && 32'(in_row) >= 32'(h_eff) && out_index < total);
  assign last_out = out_index + NW'(1) == total;
  assign col_wrap = 32'(in_col) + 32'd1 >= 32'(w_eff);
  assign sweep_last = sw_col == sw_col_end && sw_row == sw_row_end;

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:  if (emit) state_next = ST_SWEEP;
      ST_SWEEP: if (sweep_last) state_next = ST_FLUSH;
      ST_FLUSH: state_next = ST_DIV;
      ST_DIV:   if (div_res.done) state_next = ST_OUT;
      ST_OUT:   if (out_ready) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  // State outputs.
  always_comb begin
    in_ready  = 1'b0;
    out_valid = 1'b0;
    rd_en     = 1'b0;
    div_start = 1'b0;
    unique case (state)
      ST_IDLE:  in_ready  = 1'b1;
      ST_SWEEP: rd_en     = 1'b1;
      ST_FLUSH: div_start = 1'b1;
      ST_DIV:   ;
      ST_OUT:   out_valid = 1'b1;
      default:  ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Config and frame counters.
  always_ff @(posedge clk) begin
    if (rst) begin
      window_size  <= RST_WINDOW;
      frame_width  <= RST_WIDTH;
      frame_height <= RST_HEIGHT;
      in_row       <= '0;
      in_col       <= '0;
      in_index     <= '0;
      out_row      <= '0;
      out_col      <= '0;
      out_index    <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_WINDOW: window_size  <= cfg_data[KW-1:0];
        REG_WIDTH:  frame_width  <= cfg_data;
        REG_HEIGHT: frame_height <= cfg_data;
        default:    ;
      endcase
      if (cfg_index == REG_WINDOW || cfg_index == REG_WIDTH
          || cfg_index == REG_HEIGHT) begin
        in_row    <= '0;
        in_col    <= '0;
        in_index  <= '0;
        out_row   <= '0;
        out_col   <= '0;
        out_index <= '0;
      end
    end else begin
      if (pix_take) begin
        in_index <= in_index + NW'(1);
        if (col_wrap) begin
          in_col <= '0;
          in_row <= in_row + HW'(1);
        end else begin
          in_col <= in_col + XW'(1);
        end
      end
      if (emit) begin
        if (last_out) begin
          // Frame done: restart both sides.
          in_row    <= '0;
          in_col    <= '0;
          in_index  <= '0;
          out_row   <= '0;
          out_col   <= '0;
          out_index <= '0;
        end else begin
          out_index <= out_index + NW'(1);
          if (32'(out_col) + 32'd1 >= 32'(w_eff)) begin
            out_col <= '0;
            out_row <= out_row + HW'(1);
          end else begin
            out_col <= out_col + XW'(1);
          end
        end
      end
    end
  end

  // Set up the window walk on emit, then advance it one read per cycle.
  always_ff @(posedge clk) begin
    if (emit) begin
      frame_end <= last_out;
      if (filt) begin
        sw_row       <= out_row - HW'(c);
        sw_row_end   <= out_row + HW'(c);
        sw_col       <= out_col - XW'(c);
        sw_col_start <= out_col - XW'(c);
        sw_col_end   <= out_col + XW'(c);
        divisor      <= kk;
        acc          <= SUM_W'(kk >> 1);
      end else begin
        sw_row       <= out_row;
        sw_row_end   <= out_row;
        sw_col       <= out_col;
        sw_col_start <= out_col;
        sw_col_end   <= out_col;
        divisor      <= KK_W'(1);
        acc          <= '0;
      end
    end else begin
      if (rd_en) begin
        if (sw_col == sw_col_end) begin
          sw_col <= sw_col_start;
          sw_row <= sw_row + HW'(1);
        end else begin
          sw_col <= sw_col + XW'(1);
        end
      end
      if (rd_vld) begin
        acc <= acc + SUM_W'(rdata);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_vld <= 1'b0;
    end else begin
      rd_vld <= rd_en;
    end
  end

  bfwm_line_store #(
    .AW(AW)
  ) u_store (
    .clk   (clk),
    .we    (pix_take),
    .waddr ({in_row[SRW-1:0], in_col}),
    .wdata (in_data.pixel_in),
    .re    (rd_en),
    .raddr ({sw_row[SRW-1:0], sw_col}),
    .rdata (rdata)
  );

  // The last read lands during the flush cycle: fold it into the dividend.
  bfwm_mean_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (acc + SUM_W'(rdata)),
    .divisor  (divisor),
    .res      (div_res)
  );

  assign out_data.pixel_out = div_res.quotient;
  assign out_data.frame_end = frame_end;

`ifndef SYNTHESIS
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid))
    else $error("input taken while a result waits");

  a_write_idle: assert property (@(posedge clk) disable iff (rst)
    pix_take |-> state == ST_IDLE)
    else $error("line store written during a window walk");

  a_sweep_col: assert property (@(posedge clk) disable iff (rst)
    state == ST_SWEEP |-> sw_col <= sw_col_end)
    else $error("sweep column past window edge");

  a_div_done: assert property (@(posedge clk) disable iff (rst)
    div_res.done |-> state == ST_DIV)
    else $error("divider finished outside divide state");

  a_flush_read: assert property (@(posedge clk) disable iff (rst)
    state == ST_FLUSH |-> rd_vld)
    else $error("flush without the last read in flight");
`endif

endmodule

// ----- tb/tb.sv -----
// Self-checking testbench for the K by K box mean filter top level.
`timescale 1ns / 100ps

module tb;
  import bfwm_pkg::*;

  // Scoreboard: tracks the filter's line store and raster counters, predicts
  // each output beat and compares the actual beats against it in order.
  class mean_scoreboard;
    logic [PIX_W-1:0] line_mem [16][1024];
    int unsigned win_k, width_reg, height_reg;
    int unsigned row_in, col_in, next_out;
    out_item_t   expected_pixels[$];
    int unsigned results_seen;
    int unsigned errors;

    function new();
      win_k = RST_WINDOW;
      width_reg = RST_WIDTH;
      height_reg = RST_HEIGHT;
      restart_frame();
    endfunction

    function void restart_frame();
      row_in = 0;
      col_in = 0;
      next_out = 0;
    endfunction

    function int unsigned eff_w();
      return (width_reg < 1) ? 1 : (width_reg > 1024) ? 1024 : width_reg;
    endfunction

    function int unsigned eff_h();
      return (height_reg < 1) ? 1 : (height_reg > 1024) ? 1024 : height_reg;
    endfunction

    function void write_reg(logic [CIDX_W-1:0] idx, logic [CFG_W-1:0] val);
      case (idx)
        REG_WINDOW: begin
          win_k = val[KW-1:0];
          restart_frame();
        end
        REG_WIDTH: begin
          width_reg = val;
          restart_frame();
        end
        REG_HEIGHT: begin
          height_reg = val;
          restart_frame();
        end
        default: ;
      endcase
    endfunction

    // Produce the next output pixel in raster order and queue it.
    function void release_pixel(int unsigned w, int unsigned h);
      int unsigned c, r, x, sum, kk;
      bit          filt;
      out_item_t   res;
      c = win_k / 2;
      r = next_out / w;
      x = next_out % w;
      filt = win_k[0] && win_k <= 15 && win_k <= w && win_k <= h &&
             r >= c && r + c < h && x >= c && x + c < w;
      if (filt) begin
        sum = 0;
        kk = win_k * win_k;
        for (int unsigned i = r - c; i <= r + c; i++)
          for (int unsigned j = x - c; j <= x + c; j++)
            sum += line_mem[i % 16][j];
        res.pixel_out = PIX_W'((sum + kk / 2) / kk);
      end else begin
        res.pixel_out = line_mem[r % 16][x];
      end
      res.frame_end = (next_out + 1 == w * h);
      expected_pixels.push_back(res);
      next_out++;
      if (next_out >= w * h) restart_frame();
    endfunction

    // Note an accepted input beat.
    function void note_input(in_item_t it);
      int unsigned w, h, c, d, n;
      w = eff_w();
      h = eff_h();
      c = win_k / 2;
      d = c * w + c;
      if (it.kind == KIND_PIXEL) begin
        if (row_in >= h) return;
        line_mem[row_in % 16][col_in] = it.pixel_in;
        n = row_in * w + col_in;
        col_in++;
        if (col_in >= w) begin
          col_in = 0;
          row_in++;
        end
        if (n >= d) release_pixel(w, h);
      end else if (row_in >= h && next_out < w * h) begin
        release_pixel(w, h);
      end
    endfunction

    // Compare an accepted output beat with the oldest prediction.
    function void check_result(out_item_t got);
      out_item_t exp_item;
      results_seen++;
      if (expected_pixels.size() == 0) begin
        $error("unexpected output beat pixel_out=%0d frame_end=%0d",
               got.pixel_out, got.frame_end);
        errors++;
        return;
      end
      exp_item = expected_pixels.pop_front();
      if (got.pixel_out !== exp_item.pixel_out) begin
        $error("pixel_out: expected %0d, got %0d", exp_item.pixel_out, got.pixel_out);
        errors++;
      end
      if (got.frame_end !== exp_item.frame_end) begin
        $error("frame_end: expected %0d, got %0d", exp_item.frame_end, got.frame_end);
        errors++;
      end
    endfunction
  endclass

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              in_valid = 1'b0;
  logic              in_ready;
  in_item_t          in_data = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  out_item_t         out_data;
  logic              cfg_we = 1'b0;
  logic [CIDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]  cfg_data = '0;

  mean_scoreboard sb = new();
  int unsigned    beats_sent = 0;
  int unsigned    frames_run = 0;
  bit             stim_done = 1'b0;

  always #2 clk = ~clk;

  box_filter_window_mean_top u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // Idling is switched off for a stretch in the middle of the run.
  function automatic bit quiet_stretch(int unsigned count);
    return count >= 450 && count < 750;
  endfunction

  // Offer one beat; hold valid and payload until it is taken.
  task automatic send_beat(logic kind, logic [PIX_W-1:0] pix);
    in_item_t it;
    if (!quiet_stretch(beats_sent) && $urandom_range(0, 99) < 9) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat ($urandom_range(0, 4)) @(negedge clk);
    end
    it.kind = kind;
    it.pixel_in = pix;
    @(negedge clk);
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (!in_ready);
    sb.note_input(it);
  endtask

  task automatic drop_valid();
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  // Wait until every predicted beat is out, then let the block settle.
  task automatic wait_drained();
    drop_valid();
    while (sb.expected_pixels.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  task automatic write_reg(logic [CIDX_W-1:0] idx, logic [CFG_W-1:0] val);
    @(negedge clk);
    in_valid <= 1'b0;
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    sb.write_reg(idx, val);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Configure, stream npix pixels (0 = whole frame), drain the tail.
  // Noise adds early drains, a stray pixel and a stray drain.
  task automatic run_frame(int unsigned k, int unsigned w, int unsigned h,
                           int unsigned npix, bit noise, bit extremes);
    int unsigned we, he, total, pend, c;
    wait_drained();
    write_reg(REG_HEIGHT, CFG_W'(h));
    write_reg(REG_WINDOW, CFG_W'(k));
    write_reg(REG_WIDTH, CFG_W'(w));
    we = sb.eff_w();
    he = sb.eff_h();
    total = we * he;
    c = k / 2;
    pend = (c * we + c < total) ? c * we + c : total;
    for (int unsigned i = 0; i < ((npix != 0) ? npix : total); i++) begin
      if (noise && $urandom_range(0, 99) < 3)
        send_beat(KIND_DRAIN, PIX_W'($urandom()));
      send_beat(KIND_PIXEL, extremes ? ($urandom_range(0, 1) ? 8'hFF : 8'h00)
                                     : PIX_W'($urandom()));
      beats_sent++;
    end
    if (npix == 0) begin
      if (noise && pend != 0) send_beat(KIND_PIXEL, PIX_W'($urandom()));
      for (int unsigned i = 0; i < pend; i++) begin
        send_beat(KIND_DRAIN, PIX_W'($urandom()));
        beats_sent++;
      end
      if (noise) send_beat(KIND_DRAIN, PIX_W'($urandom()));
    end
    frames_run++;
  endtask

  // Receiver: random stalls, one long hold-off, no stalls mid-run.
  initial begin : receiver
    int unsigned hold_left;
    bit          held;
    hold_left = 0;
    held = 1'b0;
    forever begin
      @(negedge clk);
      if (!held && sb.results_seen >= 150) begin
        held = 1'b1;
        hold_left = 600;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= quiet_stretch(sb.results_seen) || ($urandom_range(0, 99) >= 9);
      end
      @(posedge clk);
      if (out_valid && out_ready) sb.check_result(out_data);
    end
  end

  initial begin : stimulus
    int unsigned k, w, h;
    bit          paused;
    paused = 1'b0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: all-black/all-white pixels, early drains, stray beats.
    run_frame(3, 5, 4, 0, 1'b1, 1'b1);
    // Unknown register index must leave the setup alone.
    write_reg(2'd3, 11'h7FF);
    // Register extremes: width 0 and height 2047 clamp; restart mid-frame.
    run_frame(1, 0, 2047, 12, 1'b0, 1'b1);
    run_frame(15, 15, 15, 0, 1'b0, 1'b0);
    run_frame(0, 3, 3, 0, 1'b0, 1'b0);
    run_frame(14, 4, 3, 0, 1'b0, 1'b0);
    run_frame(7, 4, 9, 0, 1'b1, 1'b0);
    run_frame(1, 2047, 0, 300, 1'b0, 1'b0);

    while (beats_sent < 1100) begin
      if ($urandom_range(0, 9) < 7) k = 2 * $urandom_range(0, 3) + 1;
      else k = $urandom_range(0, 15);
      if (k > 7) begin
        w = $urandom_range(k - 2, k + 3);
        h = $urandom_range(k - 2, k + 3);
      end else begin
        w = $urandom_range(1, 20);
        h = $urandom_range(1, 14);
      end
      run_frame(k, w, h, 0, $urandom_range(0, 3) == 0, 1'b0);
      if (!paused && beats_sent > 850) begin
        paused = 1'b1;
        drop_valid();
        while (sb.expected_pixels.size() != 0) @(posedge clk);
      end
    end
    wait_drained();
    stim_done = 1'b1;

    $display("tb: %0d frames over window sizes 0..15, clamped and extreme geometry,",
             frames_run);
    $display("tb: %0d counted input beats, %0d output beats checked",
             beats_sent, sb.results_seen);
    if (sb.errors == 0 && sb.expected_pixels.size() == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

  initial begin : watchdog
    #20ms;
    $display("tb: done, errors");
    $finish;
  end

endmodule
